### design/irpwd_pkg.sv
package irpwd_pkg;

  localparam int unsigned DurWidth   = 16;
  localparam int unsigned CodeWidth  = 8;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned NumRegs    = 8;
  localparam int unsigned CfgIdxWidth = 4;
  localparam int unsigned RegIdxWidth = 3;

  // durations in one complete frame, leading gap included
  localparam logic [CountWidth-1:0] FrameDurations = 5'd18;
  localparam logic [CountWidth-1:0] CountMax       = 5'd31;

  // positions within a frame
  localparam logic [CountWidth-1:0] PosHeaderMark  = 5'd1;
  localparam logic [CountWidth-1:0] PosHeaderSpace = 5'd2;
  localparam logic [CountWidth-1:0] PosFirstPair   = 5'd3;
  localparam logic [CountWidth-1:0] PosLastPair    = 5'd16;
  localparam logic [CountWidth-1:0] PosFinal       = 5'd17;

  typedef enum logic [RegIdxWidth-1:0] {
    REG_HDR_MARK_LO  = 3'd0,
    REG_HDR_MARK_HI  = 3'd1,
    REG_HDR_SPACE_LO = 3'd2,
    REG_HDR_SPACE_HI = 3'd3,
    REG_LONG_LO      = 3'd4,
    REG_LONG_HI      = 3'd5,
    REG_SHORT_LO     = 3'd6,
    REG_SHORT_HI     = 3'd7
  } reg_idx_t;

  typedef logic [DurWidth-1:0] dur_t;

  // window defaults: 25 % tolerance, 50 us ticks
  localparam dur_t HdrMarkLoReset  = 16'd102;
  localparam dur_t HdrMarkHiReset  = 16'd171;
  localparam dur_t HdrSpaceLoReset = 16'd6;
  localparam dur_t HdrSpaceHiReset = 16'd12;
  localparam dur_t LongLoReset     = 16'd26;
  localparam dur_t LongHiReset     = 16'd45;
  localparam dur_t ShortLoReset    = 16'd9;
  localparam dur_t ShortHiReset    = 16'd17;

  // pulse class bits
  localparam int unsigned ClassLong  = 0;
  localparam int unsigned ClassShort = 1;

  function automatic logic in_window(input dur_t d, input dur_t lo, input dur_t hi);
    in_window = (d >= lo) && (d <= hi);
  endfunction

endpackage

### design/ir_pulse_width_frame_decoder.sv
// Infrared pulse-width frame decoder. Each input word carries one captured
// mark or space length in timer ticks (s_tdata[15:0]); s_tlast flags the last
// length of a frame. The first length is the leading gap and is skipped, the
// next two must fall in the header mark and header space windows, lengths
// 3..16 decode as seven long/short pairs (long-short is 0, short-long is 1,
// anything else fails) and the final length gives 0 when long, 1 otherwise.
// One result word leaves per frame, registered when the flagged length is taken:
// m_tuser is the pass flag (exactly 18 lengths and every check met) and
// m_tdata[7:0] the 8-bit code, first bit in the msb, zero on a failed frame.
// A length is taken every clock; the only hold-off is a result word that sits
// unread in the output register, which keeps s_tready low until taken. The
// eight window bounds (inclusive, 16 bits; indices above 7 are ignored) are
// written through the cfg port by the user while the block is idle, unenforced.
module ir_pulse_width_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] duration_ticks
  input  logic        s_tlast,   // frame_end
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] code
  output logic        m_tuser    // [0] decode_ok
);

  // window registers
  irpwd_pkg::dur_t win_regs [irpwd_pkg::NumRegs];

  // frame state
  logic [irpwd_pkg::CountWidth-1:0] duration_count;
  logic [1:0]                       pair_first_class;
  logic [irpwd_pkg::CodeWidth-1:0]  bit_shift;
  logic                             frame_failed;

  logic [irpwd_pkg::CountWidth-1:0] duration_count_next;
  logic [1:0]                       pair_first_class_next;
  logic [irpwd_pkg::CodeWidth-1:0]  bit_shift_next;
  logic                             frame_failed_next;

  logic            in_take;
  logic            out_take;
  logic [1:0]      cls;
  logic            pair_bit;
  logic            pair_ok;
  logic            frame_ok;
  irpwd_pkg::dur_t d;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_take   = s_tvalid && s_tready;
  assign out_take  = m_tvalid && m_tready;
  assign d         = s_tdata;

  // long / short classification of the incoming length
  always_comb begin
    cls = '0;
    cls[irpwd_pkg::ClassLong] = irpwd_pkg::in_window(d,
      win_regs[irpwd_pkg::REG_LONG_LO], win_regs[irpwd_pkg::REG_LONG_HI]);
    cls[irpwd_pkg::ClassShort] = irpwd_pkg::in_window(d,
      win_regs[irpwd_pkg::REG_SHORT_LO], win_regs[irpwd_pkg::REG_SHORT_HI]);
  end

  // pair decode: long-short wins when the windows overlap
  always_comb begin
    pair_bit = 1'b0;
    pair_ok  = 1'b1;
    if (pair_first_class[irpwd_pkg::ClassLong] && cls[irpwd_pkg::ClassShort]) begin
      pair_bit = 1'b0;
    end else if (pair_first_class[irpwd_pkg::ClassShort] &&
                 cls[irpwd_pkg::ClassLong]) begin
      pair_bit = 1'b1;
    end else begin
      pair_ok = 1'b0;
    end
  end

  // per-length state update
  always_comb begin
    pair_first_class_next = pair_first_class;
    bit_shift_next        = bit_shift;
    frame_failed_next     = frame_failed;

    if (duration_count == irpwd_pkg::PosHeaderMark) begin
      if (!irpwd_pkg::in_window(d, win_regs[irpwd_pkg::REG_HDR_MARK_LO],
                                win_regs[irpwd_pkg::REG_HDR_MARK_HI])) begin
        frame_failed_next = 1'b1;
      end
    end else if (duration_count == irpwd_pkg::PosHeaderSpace) begin
      if (!irpwd_pkg::in_window(d, win_regs[irpwd_pkg::REG_HDR_SPACE_LO],
                                win_regs[irpwd_pkg::REG_HDR_SPACE_HI])) begin
        frame_failed_next = 1'b1;
      end
    end else if (duration_count >= irpwd_pkg::PosFirstPair &&
                 duration_count <= irpwd_pkg::PosLastPair) begin
      if (duration_count[0]) begin
        // first member of a pair
        pair_first_class_next = cls;
      end else begin
        bit_shift_next = {bit_shift[irpwd_pkg::CodeWidth-2:0], pair_bit};
        if (!pair_ok) begin
          frame_failed_next = 1'b1;
        end
      end
    end else if (duration_count == irpwd_pkg::PosFinal) begin
      bit_shift_next = {bit_shift[irpwd_pkg::CodeWidth-2:0],
                        !cls[irpwd_pkg::ClassLong]};
    end else if (duration_count >= irpwd_pkg::FrameDurations) begin
      // too many lengths
      frame_failed_next = 1'b1;
    end

    if (duration_count < irpwd_pkg::CountMax) begin
      duration_count_next = duration_count + 5'd1;
    end else begin
      duration_count_next = duration_count;
    end
  end

  assign frame_ok = !frame_failed_next && (duration_count == irpwd_pkg::PosFinal);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_regs[irpwd_pkg::REG_HDR_MARK_LO]  <= irpwd_pkg::HdrMarkLoReset;
      win_regs[irpwd_pkg::REG_HDR_MARK_HI]  <= irpwd_pkg::HdrMarkHiReset;
      win_regs[irpwd_pkg::REG_HDR_SPACE_LO] <= irpwd_pkg::HdrSpaceLoReset;
      win_regs[irpwd_pkg::REG_HDR_SPACE_HI] <= irpwd_pkg::HdrSpaceHiReset;
      win_regs[irpwd_pkg::REG_LONG_LO]      <= irpwd_pkg::LongLoReset;
      win_regs[irpwd_pkg::REG_LONG_HI]      <= irpwd_pkg::LongHiReset;
      win_regs[irpwd_pkg::REG_SHORT_LO]     <= irpwd_pkg::ShortLoReset;
      win_regs[irpwd_pkg::REG_SHORT_HI]     <= irpwd_pkg::ShortHiReset;
    end else if (cfg_valid && cfg_ready &&
                 cfg_index < irpwd_pkg::CfgIdxWidth'(irpwd_pkg::NumRegs)) begin
      win_regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  // frame state, rearmed on the last length
  always_ff @(posedge clk) begin
    if (rst) begin
      duration_count   <= '0;
      pair_first_class <= '0;
      bit_shift        <= '0;
      frame_failed     <= 1'b0;
    end else if (in_take) begin
      if (s_tlast) begin
        duration_count   <= '0;
        pair_first_class <= '0;
        bit_shift        <= '0;
        frame_failed     <= 1'b0;
      end else begin
        duration_count   <= duration_count_next;
        pair_first_class <= pair_first_class_next;
        bit_shift        <= bit_shift_next;
        frame_failed     <= frame_failed_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_take && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (out_take) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && s_tlast) begin
      m_tuser <= frame_ok;
      m_tdata <= frame_ok ? bit_shift_next : '0;
    end
  end

  // checks
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_take && s_tlast) |=> m_tvalid)
    else $error("no result after last length");

  a_fail_zero_code: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("failed frame carries a non-zero code");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (in_take && s_tlast) |=> (duration_count == '0 && !frame_failed))
    else $error("frame state not rearmed");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (in_take && !s_tlast && duration_count != irpwd_pkg::CountMax) |=>
      (duration_count == $past(duration_count) + 5'd1))
    else $error("length count did not advance");

  a_no_result_mid_frame: assert property (@(posedge clk) disable iff (rst)
    (in_take && !s_tlast && !m_tvalid) |=> !m_tvalid)
    else $error("result without last length");

endmodule
